// ----- src/scsa_pkg.sv -----
package scsa_pkg;

    // Pool geometry and size classes.
    localparam int NUM_PAGES        = 64;
    localparam int PAGE_BYTES       = 4096;
    localparam int NUM_CLASSES      = 7;
    localparam int MIN_OBJECT_BYTES = 32;

    localparam int SLOT_SPAN   = PAGE_BYTES / MIN_OBJECT_BYTES;
    localparam int MAX_REQUEST = MIN_OBJECT_BYTES << (NUM_CLASSES - 1);

    // Field and index widths.
    localparam int PG_W    = $clog2(NUM_PAGES);
    localparam int PTR_W   = PG_W + 1;
    localparam int SLOT_W  = $clog2(SLOT_SPAN);
    localparam int OFF_W   = $clog2(PAGE_BYTES);
    localparam int MIN_SH  = $clog2(MIN_OBJECT_BYTES);
    localparam int SH_W    = $clog2(OFF_W + 1);
    localparam int CLS_W   = 3;
    localparam int CNT_W   = SLOT_W;
    localparam int FOBJ_W  = 13;
    localparam int SADDR_W = PG_W + SLOT_W;
    localparam int ADDR_W  = 18;
    localparam int SIZE_W  = 16;
    localparam int THR_W   = 7;

    // Request kinds.
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_SIZE = 2'd1,
        ST_NO_PAGE  = 2'd2,
        ST_BAD_FREE = 2'd3
    } t_status;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_FILL,
        S_ASTART,
        S_AWALK,
        S_ATAKE,
        S_FCHK,
        S_FWALK,
        S_FPUSH,
        S_RSTART,
        S_RWALK,
        S_OUT
    } t_state;

    // Per-page descriptor held in the page memory.
    typedef struct packed {
        logic [CLS_W-1:0] cls;
        logic [CNT_W-1:0] cnt;
        logic [SLOT_W-1:0] head;
        logic [PTR_W-1:0] link;
    } t_meta;

    // Usable slots in one page of a class; slot 0 is reserved.
    function automatic logic [CNT_W-1:0] class_slots(input logic [CLS_W-1:0] c);
        logic [SLOT_W:0] q;
        q = (SLOT_W + 1)'(SLOT_SPAN) >> c;
        return CNT_W'(q - (SLOT_W + 1)'(1));
    endfunction

endpackage

// ----- src/scsa_req_if.sv -----
interface scsa_req_if;
    import scsa_pkg::*;

    logic              valid;
    logic              ready;
    logic              kind;
    logic [SIZE_W-1:0] request_size;
    logic [ADDR_W-1:0] free_address;

    modport source (output valid, output kind, output request_size, output free_address,
                    input ready);
    modport sink (input valid, input kind, input request_size, input free_address,
                  output ready);
endinterface

// ----- src/scsa_rsp_if.sv -----
interface scsa_rsp_if;
    import scsa_pkg::*;

    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] object_address;
    logic [1:0]        status;
    logic [CLS_W-1:0]  size_class;
    logic              page_released;

    modport source (output valid, output object_address, output status,
                    output size_class, output page_released, input ready);
    modport sink (input valid, input object_address, input status,
                  input size_class, input page_released, output ready);
endinterface

// ----- src/scsa_ram.sv -----
module scsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/size_class_slab_allocator.sv -----
// Slab allocator over a pool of 64 pages of 4096 bytes with seven power-of-two size
// classes from 32 to 2048 bytes. Each request is a transfer on i_req and produces exactly
// one transfer on o_rsp; one request is in work at a time, and the next is taken while the
// previous result waits in the output register. Page descriptors live in a 64-entry memory
// and free-list links in an 8192-entry memory, both with a registered read port. An allocate
// walks the class page list to the first page with a free slot; one that refills its class
// first builds the free list of a new page, one link per slot (up to 127 slots). A free checks
// the page free list for a double free and walks the class page list when a whole page goes
// back to the pool. No clearing pass runs after reset. The threshold register may be written
// at any time the block is idle.
module size_class_slab_allocator (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [scsa_pkg::THR_W-1:0] i_cfg_data,
    scsa_req_if.sink                   i_req,
    scsa_rsp_if.source                 o_rsp
);
    import scsa_pkg::*;

    localparam logic [PTR_W-1:0] PTR_NONE  = PTR_W'(NUM_PAGES);
    localparam logic [CNT_W-1:0] STEP_LAST = CNT_W'(NUM_PAGES - 1);

    t_state r_state, n_state;
    logic [NUM_PAGES-1:0] r_used, n_used;
    logic [PTR_W-1:0]  r_list_head [NUM_CLASSES];
    logic [PTR_W-1:0]  n_list_head [NUM_CLASSES];
    logic [FOBJ_W-1:0] r_free_obj [NUM_CLASSES];
    logic [FOBJ_W-1:0] n_free_obj [NUM_CLASSES];
    logic [THR_W-1:0]  r_whole [NUM_CLASSES];
    logic [THR_W-1:0]  n_whole [NUM_CLASSES];
    logic [THR_W-1:0]  r_thresh, n_thresh;

    logic [CLS_W-1:0]  r_cls, n_cls;
    logic [CNT_W-1:0]  r_slots, n_slots;
    logic [PG_W-1:0]   r_pg, n_pg;
    logic [OFF_W-1:0]  r_off, n_off;
    logic [SLOT_W-1:0] r_s, n_s;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [PTR_W-1:0]  r_cur, n_cur;
    logic [PTR_W-1:0]  r_prev, n_prev;
    t_meta             r_meta, n_meta;
    t_meta             r_prev_meta, n_prev_meta;

    logic [ADDR_W-1:0] r_res_addr, n_res_addr;
    t_status           r_res_status, n_res_status;
    logic [CLS_W-1:0]  r_res_cls, n_res_cls;
    logic              r_res_rel, n_res_rel;

    logic              r_ov, n_ov;
    logic [ADDR_W-1:0] r_oaddr;
    t_status           r_ostatus;
    logic [CLS_W-1:0]  r_ocls;
    logic              r_orel;
    logic              out_load;

    // Memory ports.
    logic                meta_we;
    logic [PG_W-1:0]     meta_waddr, meta_raddr;
    t_meta               meta_wdata, meta_rd;
    logic [$bits(t_meta)-1:0] meta_rdata;
    logic                slot_we;
    logic [SADDR_W-1:0]  slot_waddr, slot_raddr;
    logic [SLOT_W-1:0]   slot_wdata, slot_rdata;

    // Request decode.
    logic [CLS_W-1:0]  req_cls;
    logic              req_bad_size;
    logic [PG_W-1:0]   fp;
    logic              fp_found;

    // Free checks on the descriptor just read.
    logic [SH_W-1:0]   chk_shift;
    logic [OFF_W-1:0]  chk_mask;
    logic [OFF_W-1:0]  chk_sfull;
    logic [SLOT_W-1:0] chk_s;
    logic              chk_bad;

    logic [SH_W-1:0]   alloc_shift;
    logic [OFF_W-1:0]  alloc_off;
    logic [CNT_W-1:0]  push_cnt;
    logic [THR_W-1:0]  push_whole;
    logic [PTR_W-1:0]  cls_head;

    scsa_ram #(.WIDTH($bits(t_meta)), .DEPTH(NUM_PAGES)) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (meta_we),
        .i_waddr (meta_waddr),
        .i_wdata (meta_wdata),
        .i_raddr (meta_raddr),
        .o_rdata (meta_rdata)
    );

    scsa_ram #(.WIDTH(SLOT_W), .DEPTH(NUM_PAGES * SLOT_SPAN)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_raddr (slot_raddr),
        .o_rdata (slot_rdata)
    );

    assign meta_rd = t_meta'(meta_rdata);

    // Round the request size up to a class.
    always_comb begin
        req_cls = CLS_W'(NUM_CLASSES - 1);
        for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
            if (i_req.request_size <= SIZE_W'(MIN_OBJECT_BYTES << i)) begin
                req_cls = CLS_W'(i);
            end
        end
        req_bad_size = (i_req.request_size == '0) ||
                       (i_req.request_size > SIZE_W'(MAX_REQUEST));
    end

    // Lowest unused pool page.
    always_comb begin
        fp       = '0;
        fp_found = 1'b0;
        for (int i = NUM_PAGES - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                fp       = PG_W'(i);
                fp_found = 1'b1;
            end
        end
    end

    // Slot index and alignment of a freed address.
    always_comb begin
        chk_shift = SH_W'(MIN_SH) + SH_W'(meta_rd.cls);
        chk_mask  = (OFF_W'(1) << chk_shift) - OFF_W'(1);
        chk_sfull = r_off >> chk_shift;
        chk_s     = chk_sfull[SLOT_W-1:0];
        chk_bad   = (meta_rd.cls >= CLS_W'(NUM_CLASSES)) || ((r_off & chk_mask) != '0) ||
                    (chk_s == '0) || (chk_s > class_slots(meta_rd.cls));
    end

    assign alloc_shift = SH_W'(MIN_SH) + SH_W'(r_cls);
    assign alloc_off   = OFF_W'(r_meta.head) << alloc_shift;
    assign push_cnt    = r_meta.cnt + CNT_W'(1);
    assign push_whole  = r_whole[r_cls] + THR_W'(push_cnt == r_slots);
    assign cls_head    = r_list_head[r_cls];

    // Sequencer: next state, table updates and memory accesses.
    always_comb begin
        n_state      = r_state;
        n_used       = r_used;
        n_list_head  = r_list_head;
        n_free_obj   = r_free_obj;
        n_whole      = r_whole;
        n_thresh     = i_cfg_we ? i_cfg_data : r_thresh;
        n_cls        = r_cls;
        n_slots      = r_slots;
        n_pg         = r_pg;
        n_off        = r_off;
        n_s          = r_s;
        n_cnt        = r_cnt;
        n_cur        = r_cur;
        n_prev       = r_prev;
        n_meta       = r_meta;
        n_prev_meta  = r_prev_meta;
        n_res_addr   = r_res_addr;
        n_res_status = r_res_status;
        n_res_cls    = r_res_cls;
        n_res_rel    = r_res_rel;
        meta_we      = 1'b0;
        meta_waddr   = r_pg;
        meta_wdata   = r_meta;
        meta_raddr   = '0;
        slot_we      = 1'b0;
        slot_waddr   = {r_pg, r_s};
        slot_wdata   = '0;
        slot_raddr   = '0;

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_res_addr = '0;
                    n_res_rel  = 1'b0;
                    n_res_cls  = '0;
                    if (i_req.kind == KIND_ALLOC) begin
                        n_cls   = req_cls;
                        n_slots = class_slots(req_cls);
                        if (req_bad_size) begin
                            n_res_status = ST_BAD_SIZE;
                            n_state      = S_OUT;
                        end else if (r_free_obj[req_cls] == '0) begin
                            if (!fp_found) begin
                                n_res_status = ST_NO_PAGE;
                                n_res_cls    = req_cls;
                                n_state      = S_OUT;
                            end else begin
                                n_pg    = fp;
                                n_s     = SLOT_W'(1);
                                n_state = S_FILL;
                            end
                        end else begin
                            n_state = S_ASTART;
                        end
                    end else begin
                        n_pg  = i_req.free_address[OFF_W +: PG_W];
                        n_off = i_req.free_address[OFF_W-1:0];
                        if (!r_used[i_req.free_address[OFF_W +: PG_W]]) begin
                            n_res_status = ST_BAD_FREE;
                            n_state      = S_OUT;
                        end else begin
                            meta_raddr = i_req.free_address[OFF_W +: PG_W];
                            n_state    = S_FCHK;
                        end
                    end
                end
            end

            // Build the free list of a new page, one link a cycle.
            S_FILL: begin
                slot_we    = 1'b1;
                slot_waddr = {r_pg, r_s};
                slot_wdata = r_s - SLOT_W'(1);
                n_s        = r_s + SLOT_W'(1);
                if (r_s == r_slots) begin
                    meta_we    = 1'b1;
                    meta_waddr = r_pg;
                    meta_wdata = '{cls: r_cls, cnt: r_slots, head: r_slots, link: cls_head};
                    n_used[r_pg]       = 1'b1;
                    n_list_head[r_cls] = {1'b0, r_pg};
                    n_whole[r_cls]     = r_whole[r_cls] + THR_W'(1);
                    n_free_obj[r_cls]  = r_free_obj[r_cls] + FOBJ_W'(r_slots);
                    n_state            = S_ASTART;
                end
            end

            S_ASTART: begin
                n_cur = cls_head;
                n_cnt = '0;
                if (cls_head >= PTR_NONE) begin
                    n_res_status = ST_NO_PAGE;
                    n_res_cls    = r_cls;
                    n_state      = S_OUT;
                end else begin
                    meta_raddr = cls_head[PG_W-1:0];
                    n_state    = S_AWALK;
                end
            end

            // Walk the class page list to the first page with a free slot.
            S_AWALK: begin
                if (meta_rd.cnt != '0) begin
                    n_meta     = meta_rd;
                    slot_raddr = {r_cur[PG_W-1:0], meta_rd.head};
                    n_state    = S_ATAKE;
                end else if (meta_rd.link >= PTR_NONE || r_cnt == STEP_LAST) begin
                    n_res_status = ST_NO_PAGE;
                    n_res_cls    = r_cls;
                    n_state      = S_OUT;
                end else begin
                    n_cur      = meta_rd.link;
                    n_cnt      = r_cnt + CNT_W'(1);
                    meta_raddr = meta_rd.link[PG_W-1:0];
                end
            end

            // Pop the head slot; the link read gives the new head.
            S_ATAKE: begin
                meta_we    = 1'b1;
                meta_waddr = r_cur[PG_W-1:0];
                meta_wdata = '{cls: r_meta.cls, cnt: r_meta.cnt - CNT_W'(1),
                               head: slot_rdata, link: r_meta.link};
                if (r_meta.cnt == r_slots && r_whole[r_cls] != '0) begin
                    n_whole[r_cls] = r_whole[r_cls] - THR_W'(1);
                end
                n_free_obj[r_cls] = r_free_obj[r_cls] - FOBJ_W'(1);
                n_res_addr   = {r_cur[PG_W-1:0], alloc_off};
                n_res_status = ST_OK;
                n_res_cls    = r_cls;
                n_state      = S_OUT;
            end

            // Validate the freed slot against its page descriptor.
            S_FCHK: begin
                if (chk_bad) begin
                    n_res_status = ST_BAD_FREE;
                    n_state      = S_OUT;
                end else begin
                    n_meta  = meta_rd;
                    n_cls   = meta_rd.cls;
                    n_slots = class_slots(meta_rd.cls);
                    n_s     = chk_s;
                    if (meta_rd.cnt == '0) begin
                        n_state = S_FPUSH;
                    end else if (meta_rd.head == chk_s) begin
                        n_res_status = ST_BAD_FREE;
                        n_state      = S_OUT;
                    end else begin
                        slot_raddr = {r_pg, meta_rd.head};
                        n_cnt      = CNT_W'(1);
                        n_state    = S_FWALK;
                    end
                end
            end

            // Search the page free list for a double free.
            S_FWALK: begin
                if (r_cnt < r_meta.cnt) begin
                    if (slot_rdata == r_s) begin
                        n_res_status = ST_BAD_FREE;
                        n_state      = S_OUT;
                    end else begin
                        slot_raddr = {r_pg, slot_rdata};
                        n_cnt      = r_cnt + CNT_W'(1);
                    end
                end else begin
                    n_state = S_FPUSH;
                end
            end

            // Push the slot and decide on a page release.
            S_FPUSH: begin
                slot_we    = 1'b1;
                slot_waddr = {r_pg, r_s};
                slot_wdata = r_meta.head;
                meta_we    = 1'b1;
                meta_waddr = r_pg;
                meta_wdata = '{cls: r_meta.cls, cnt: push_cnt, head: r_s, link: r_meta.link};
                n_free_obj[r_cls] = r_free_obj[r_cls] + FOBJ_W'(1);
                n_whole[r_cls]    = push_whole;
                n_res_status      = ST_OK;
                n_res_cls         = r_cls;
                if (push_whole > r_thresh) begin
                    n_state = S_RSTART;
                end else begin
                    n_state = S_OUT;
                end
            end

            S_RSTART: begin
                n_cur  = cls_head;
                n_prev = PTR_NONE;
                n_cnt  = '0;
                if (cls_head >= PTR_NONE) begin
                    n_state = S_OUT;
                end else begin
                    meta_raddr = cls_head[PG_W-1:0];
                    n_state    = S_RWALK;
                end
            end

            // Find the first whole-free page, unlink it and return it to the pool.
            S_RWALK: begin
                if (meta_rd.cnt == r_slots) begin
                    if (r_prev >= PTR_NONE) begin
                        n_list_head[r_cls] = meta_rd.link;
                    end else begin
                        meta_we    = 1'b1;
                        meta_waddr = r_prev[PG_W-1:0];
                        meta_wdata = '{cls: r_prev_meta.cls, cnt: r_prev_meta.cnt,
                                       head: r_prev_meta.head, link: meta_rd.link};
                    end
                    n_used[r_cur[PG_W-1:0]] = 1'b0;
                    n_whole[r_cls]    = r_whole[r_cls] - THR_W'(1);
                    n_free_obj[r_cls] = r_free_obj[r_cls] - FOBJ_W'(r_slots);
                    n_res_rel         = 1'b1;
                    n_state           = S_OUT;
                end else begin
                    n_prev      = r_cur;
                    n_prev_meta = meta_rd;
                    n_cur       = meta_rd.link;
                    n_cnt       = r_cnt + CNT_W'(1);
                    if (meta_rd.link >= PTR_NONE || r_cnt == STEP_LAST) begin
                        n_state = S_OUT;
                    end else begin
                        meta_raddr = meta_rd.link[PG_W-1:0];
                    end
                end
            end

            S_OUT: begin
                if (!r_ov || o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output register handshake.
    assign out_load = (r_state == S_OUT) && (!r_ov || o_rsp.ready);

    always_comb begin
        n_ov = r_ov;
        if (out_load) begin
            n_ov = 1'b1;
        end else if (o_rsp.ready) begin
            n_ov = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_used   <= '0;
            r_thresh <= THR_W'(2);
            r_ov     <= 1'b0;
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_list_head[c] <= PTR_NONE;
                r_free_obj[c]  <= '0;
                r_whole[c]     <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_thresh    <= n_thresh;
            r_ov        <= n_ov;
            r_list_head <= n_list_head;
            r_free_obj  <= n_free_obj;
            r_whole     <= n_whole;
        end
    end

    // Working registers and result payload.
    always_ff @(posedge i_clk) begin
        r_cls        <= n_cls;
        r_slots      <= n_slots;
        r_pg         <= n_pg;
        r_off        <= n_off;
        r_s          <= n_s;
        r_cnt        <= n_cnt;
        r_cur        <= n_cur;
        r_prev       <= n_prev;
        r_meta       <= n_meta;
        r_prev_meta  <= n_prev_meta;
        r_res_addr   <= n_res_addr;
        r_res_status <= n_res_status;
        r_res_cls    <= n_res_cls;
        r_res_rel    <= n_res_rel;
        if (out_load) begin
            r_oaddr   <= r_res_addr;
            r_ostatus <= r_res_status;
            r_ocls    <= r_res_cls;
            r_orel    <= r_res_rel;
        end
    end

    assign i_req.ready          = (r_state == S_IDLE);
    assign o_rsp.valid          = r_ov;
    assign o_rsp.object_address = r_oaddr;
    assign o_rsp.status         = r_ostatus;
    assign o_rsp.size_class     = r_ocls;
    assign o_rsp.page_released  = r_orel;

endmodule
